// ===== hw/rtl/tsu_pkg.sv =====
`timescale 1ns / 1ps
package tsu_pkg;

   // token kinds
   localparam logic [3:0] KIND_SYMBOL      = 4'd0;
   localparam logic [3:0] KIND_ESC_SYMBOL  = 4'd1;
   localparam logic [3:0] KIND_STRING      = 4'd2;
   localparam logic [3:0] KIND_GROUP_OPEN  = 4'd3;
   localparam logic [3:0] KIND_GROUP_CLOSE = 4'd4;
   localparam logic [3:0] KIND_LOOP_OPEN   = 4'd5;
   localparam logic [3:0] KIND_LOOP_CLOSE  = 4'd6;
   localparam logic [3:0] KIND_ERROR       = 4'd7;
   localparam logic [3:0] KIND_END         = 4'd8;

   localparam logic [7:0] QUOTE_CHAR   = 8'h22;
   localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
   localparam logic [7:0] BSLASH_CHAR  = 8'h5C;

   // configuration register indexes
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMENT     = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DELIMITER   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_GROUP_OPEN  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GROUP_CLOSE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOP_OPEN   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOOP_CLOSE  = 3'd5;

   localparam logic [7:0] RST_COMMENT     = 8'd35;
   localparam logic [7:0] RST_DELIMITER   = 8'd44;
   localparam logic [7:0] RST_GROUP_OPEN  = 8'd40;
   localparam logic [7:0] RST_GROUP_CLOSE = 8'd41;
   localparam logic [7:0] RST_LOOP_OPEN   = 8'd123;
   localparam logic [7:0] RST_LOOP_CLOSE  = 8'd125;

   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [7:0] comment_char;
      logic [7:0] delimiter_char;
      logic [7:0] group_open_char;
      logic [7:0] group_close_char;
      logic [7:0] loop_open_char;
      logic [7:0] loop_close_char;
   } cfg_type;

   // one result item, less the end-of-run flag which the back end adds
   typedef struct packed {
      logic [3:0] token_kind;
      logic [7:0] token_byte;
      logic       byte_valid;
      logic       first_of_token;
      logic       last_of_token;
   } res_type;

   // all results caused by one input item
   typedef struct packed {
      logic [1:0]                   count;
      res_type [MAX_RESULTS-1:0]    slot;
   } run_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

endpackage

// ===== hw/rtl/tsu_req_if.sv =====
`timescale 1ns / 1ps
interface tsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_input;

   modport source (output valid, output data_byte, output end_of_input, input ready);
   modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

// ===== hw/rtl/tsu_rsp_if.sv =====
`timescale 1ns / 1ps
interface tsu_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] token_kind;
   logic [7:0] token_byte;
   logic       byte_valid;
   logic       first_of_token;
   logic       last_of_token;
   logic       last_of_run;

   modport source (output valid, output token_kind, output token_byte, output byte_valid,
                   output first_of_token, output last_of_token, output last_of_run,
                   input ready);
   modport sink (input valid, input token_kind, input token_byte, input byte_valid,
                 input first_of_token, input last_of_token, input last_of_run,
                 output ready);
endinterface

// ===== hw/rtl/tsu_front.sv =====
`timescale 1ns / 1ps
module tsu_front import tsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   tsu_req_if.sink    req,
   input  q_stat_type q_stat,
   output logic       q_push,
   output run_type    q_data
);

   typedef enum logic [2:0] {
      M_IDLE,
      M_COMMENT,
      M_AFTER_DELIM,
      M_SYMBOL,
      M_SYMBOL_ESC,
      M_STRING,
      M_STRING_ESC
   } mode_type;

   // outcome of a byte that may open a token
   typedef struct packed {
      logic       emit;
      res_type    res;
      mode_type   mode;
      logic       hold;
      logic [1:0] kind;
   } start_type;

   mode_type   mode_ff, mode_in;
   logic [7:0] held_byte_ff, held_byte_in;
   logic       held_valid_ff, held_valid_in;
   logic       held_first_ff, held_first_in;
   logic [1:0] kind_ff, kind_in;
   run_type    run_v;
   logic       accept;

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
   endfunction

   function automatic logic is_term(input logic [7:0] b, input cfg_type c);
      return is_space(b) || (b == c.comment_char) || (b == c.group_open_char) ||
             (b == c.group_close_char) || (b == c.loop_open_char) ||
             (b == c.loop_close_char) || (b == c.delimiter_char);
   endfunction

   function automatic start_type start_tok(input logic [7:0] b, input cfg_type c);
      start_type s;
      s = '0;
      s.mode = M_IDLE;
      if (b == BSLASH_CHAR) begin
         s.hold = 1'b1;
         s.kind = KIND_ESC_SYMBOL[1:0];
         s.mode = M_SYMBOL;
      end else if (b == c.group_open_char) begin
         s.emit = 1'b1;
         s.res = '{KIND_GROUP_OPEN, b, 1'b1, 1'b1, 1'b1};
      end else if (b == c.group_close_char) begin
         s.emit = 1'b1;
         s.res = '{KIND_GROUP_CLOSE, b, 1'b1, 1'b1, 1'b1};
      end else if (b == c.loop_open_char) begin
         s.emit = 1'b1;
         s.res = '{KIND_LOOP_OPEN, b, 1'b1, 1'b1, 1'b1};
      end else if (b == c.loop_close_char) begin
         s.emit = 1'b1;
         s.res = '{KIND_LOOP_CLOSE, b, 1'b1, 1'b1, 1'b1};
      end else if (b == QUOTE_CHAR) begin
         s.hold = 1'b1;
         s.kind = KIND_STRING[1:0];
         s.mode = M_STRING;
      end else if (is_term(b, c)) begin
         // empty symbol token
         s.emit = 1'b1;
         s.res = '{KIND_SYMBOL, 8'd0, 1'b0, 1'b1, 1'b1};
         if (b == c.comment_char) begin
            s.mode = (b == NEWLINE_CHAR) ? M_IDLE : M_COMMENT;
         end else if (b == c.delimiter_char) begin
            s.mode = M_AFTER_DELIM;
         end
      end else begin
         s.hold = 1'b1;
         s.kind = KIND_SYMBOL[1:0];
         s.mode = M_SYMBOL;
      end
      return s;
   endfunction

   function automatic start_type idle_tok(input logic [7:0] b, input cfg_type c);
      start_type s;
      s = '0;
      s.mode = M_IDLE;
      if (b == c.comment_char) begin
         s.mode = (b == NEWLINE_CHAR) ? M_IDLE : M_COMMENT;
      end else if (b == c.delimiter_char) begin
         s.mode = M_AFTER_DELIM;
      end else if (!is_space(b)) begin
         s = start_tok(b, c);
      end
      return s;
   endfunction

   assign req.ready = !q_stat.full;
   assign accept    = req.valid && req.ready;
   assign q_push    = accept && (run_v.count != 2'd0);
   assign q_data    = run_v;

   always_comb begin
      logic [1:0] n_v;
      start_type  st_v;
      res_type    held_v;
      logic [7:0] b;
      logic       use_st;

      b = req.data_byte;
      n_v = 2'd0;
      run_v = '0;
      st_v = '0;
      use_st = 1'b0;
      held_v = '{{2'b00, kind_ff}, held_byte_ff, 1'b1, held_first_ff, 1'b0};
      mode_in = mode_ff;
      held_byte_in = held_byte_ff;
      held_valid_in = held_valid_ff;
      held_first_in = held_first_ff;
      kind_in = kind_ff;

      if (req.end_of_input) begin
         case (mode_ff)
            M_SYMBOL, M_SYMBOL_ESC, M_STRING_ESC: begin
               if (held_valid_ff) begin
                  held_v.last_of_token = 1'b1;
                  run_v.slot[n_v] = held_v;
                  n_v = n_v + 2'd1;
               end
               // a pending escape turns the end marker into an error
               run_v.slot[n_v] = '{(mode_ff == M_SYMBOL) ? KIND_END : KIND_ERROR,
                                   8'd0, 1'b0, 1'b1, 1'b1};
               n_v = n_v + 2'd1;
            end
            M_STRING: begin
               if (held_valid_ff) begin
                  run_v.slot[n_v] = held_v;
                  n_v = n_v + 2'd1;
               end
               // close the open string
               run_v.slot[n_v] = '{KIND_STRING, QUOTE_CHAR, 1'b1, 1'b0, 1'b1};
               n_v = n_v + 2'd1;
               run_v.slot[n_v] = '{KIND_END, 8'd0, 1'b0, 1'b1, 1'b1};
               n_v = n_v + 2'd1;
            end
            M_AFTER_DELIM: begin
               run_v.slot[n_v] = '{KIND_ERROR, 8'd0, 1'b0, 1'b1, 1'b1};
               n_v = n_v + 2'd1;
            end
            default: begin
               run_v.slot[n_v] = '{KIND_END, 8'd0, 1'b0, 1'b1, 1'b1};
               n_v = n_v + 2'd1;
            end
         endcase
         mode_in = M_IDLE;
         held_byte_in = 8'd0;
         held_valid_in = 1'b0;
         held_first_in = 1'b0;
         kind_in = 2'd0;
      end else begin
         case (mode_ff)
            M_COMMENT: begin
               if (b == NEWLINE_CHAR) mode_in = M_IDLE;
            end
            M_AFTER_DELIM: begin
               if (is_space(b) || (b == cfg.delimiter_char)) begin
                  mode_in = M_IDLE;
               end else begin
                  st_v = start_tok(b, cfg);
                  use_st = 1'b1;
               end
            end
            M_SYMBOL: begin
               if (is_term(b, cfg)) begin
                  if (held_valid_ff) begin
                     held_v.last_of_token = 1'b1;
                     run_v.slot[n_v] = held_v;
                     n_v = n_v + 2'd1;
                  end
                  held_valid_in = 1'b0;
                  held_first_in = 1'b0;
                  st_v = idle_tok(b, cfg);
                  use_st = 1'b1;
               end else if (b == BSLASH_CHAR) begin
                  mode_in = M_SYMBOL_ESC;
               end else begin
                  if (held_valid_ff) begin
                     run_v.slot[n_v] = held_v;
                     n_v = n_v + 2'd1;
                  end
                  held_byte_in = b;
                  held_valid_in = 1'b1;
                  held_first_in = 1'b0;
               end
            end
            M_SYMBOL_ESC, M_STRING_ESC: begin
               if (held_valid_ff) begin
                  run_v.slot[n_v] = held_v;
                  n_v = n_v + 2'd1;
               end
               held_byte_in = b;
               held_valid_in = 1'b1;
               held_first_in = 1'b0;
               mode_in = (mode_ff == M_SYMBOL_ESC) ? M_SYMBOL : M_STRING;
            end
            M_STRING: begin
               if (held_valid_ff) begin
                  run_v.slot[n_v] = held_v;
                  n_v = n_v + 2'd1;
               end
               held_first_in = 1'b0;
               if (b == QUOTE_CHAR) begin
                  run_v.slot[n_v] = '{KIND_STRING, QUOTE_CHAR, 1'b1, 1'b0, 1'b1};
                  n_v = n_v + 2'd1;
                  held_valid_in = 1'b0;
                  mode_in = M_IDLE;
               end else begin
                  held_byte_in = b;
                  held_valid_in = 1'b1;
                  mode_in = (b == BSLASH_CHAR) ? M_STRING_ESC : M_STRING;
               end
            end
            default: begin
               st_v = idle_tok(b, cfg);
               use_st = 1'b1;
            end
         endcase

         if (use_st) begin
            if (st_v.emit) begin
               run_v.slot[n_v] = st_v.res;
               n_v = n_v + 2'd1;
            end
            if (st_v.hold) begin
               held_byte_in = b;
               held_valid_in = 1'b1;
               held_first_in = 1'b1;
               kind_in = st_v.kind;
            end
            mode_in = st_v.mode;
         end
      end
      run_v.count = n_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         held_byte_ff <= 8'd0;
         held_valid_ff <= 1'b0;
         held_first_ff <= 1'b0;
         kind_ff <= 2'd0;
      end else if (accept) begin
         mode_ff <= mode_in;
         held_byte_ff <= held_byte_in;
         held_valid_ff <= held_valid_in;
         held_first_ff <= held_first_in;
         kind_ff <= kind_in;
      end
   end

endmodule

// ===== hw/rtl/tsu_queue.sv =====
`timescale 1ns / 1ps
module tsu_queue import tsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  run_type    push_data,
   input  logic       pop,
   output run_type    head,
   output q_stat_type stat
);

   run_type                 entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;

   assign head = entry_ff[rd_ptr_ff];
   assign stat.full = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

// ===== hw/rtl/tsu_back.sv =====
`timescale 1ns / 1ps
module tsu_back import tsu_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  run_type    head,
   input  q_stat_type q_stat,
   output logic       q_pop,
   tsu_rsp_if.source  rsp
);

   logic [1:0] idx_ff, idx_in;
   logic       out_valid_ff, out_valid_in;
   res_type    out_ff, out_in;
   logic       out_last_run_ff, out_last_run_in;
   logic       advance;
   logic       take;
   logic       last_slot;

   assign advance = !out_valid_ff || rsp.ready;
   assign take = advance && !q_stat.empty;
   assign last_slot = (idx_ff == head.count - 2'd1);
   assign q_pop = take && last_slot;

   always_comb begin
      idx_in = idx_ff;
      out_valid_in = out_valid_ff;
      out_in = out_ff;
      out_last_run_in = out_last_run_ff;
      if (take) begin
         // step through the results of the head run, then drop it
         idx_in = last_slot ? 2'd0 : idx_ff + 2'd1;
         out_valid_in = 1'b1;
         out_in = head.slot[idx_ff];
         out_last_run_in = last_slot;
      end else if (advance) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      out_last_run_ff <= out_last_run_in;
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.token_kind = out_ff.token_kind;
   assign rsp.token_byte = out_ff.token_byte;
   assign rsp.byte_valid = out_ff.byte_valid;
   assign rsp.first_of_token = out_ff.first_of_token;
   assign rsp.last_of_token = out_ff.last_of_token;
   assign rsp.last_of_run = out_last_run_ff;

endmodule

// ===== hw/rtl/token_scanner_unit.sv =====
`timescale 1ns / 1ps
// Byte-serial tokenizer. One source byte or an end-of-input mark is taken per
// req transfer, and tokens leave on rsp one byte per transfer, each marked
// first/last of token and last of the run caused by its input byte; one byte
// of a token is held back until the next byte shows whether it is the last.
// The front end classifies a byte combinationally and takes one every cycle
// while its four-entry run queue has room; the back end drains one result per
// cycle while rsp is ready (up to 3 results per byte); a byte with no result
// is never queued. The six special characters are written through the csr
// port by the user only while the block is idle; nothing enforces this.
module token_scanner_unit import tsu_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   tsu_req_if.sink                req_chan,
   tsu_rsp_if.source              rsp_chan,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [7:0]             csr_wr_data
);

   cfg_type    cfg_ff, cfg_in;
   logic       q_push;
   logic       q_pop;
   run_type    q_data;
   run_type    q_head;
   q_stat_type q_stat;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_COMMENT:     cfg_in.comment_char = csr_wr_data;
            CSR_DELIMITER:   cfg_in.delimiter_char = csr_wr_data;
            CSR_GROUP_OPEN:  cfg_in.group_open_char = csr_wr_data;
            CSR_GROUP_CLOSE: cfg_in.group_close_char = csr_wr_data;
            CSR_LOOP_OPEN:   cfg_in.loop_open_char = csr_wr_data;
            CSR_LOOP_CLOSE:  cfg_in.loop_close_char = csr_wr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{RST_COMMENT, RST_DELIMITER, RST_GROUP_OPEN, RST_GROUP_CLOSE,
                     RST_LOOP_OPEN, RST_LOOP_CLOSE};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tsu_front u_front (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .req    (req_chan),
      .q_stat (q_stat),
      .q_push (q_push),
      .q_data (q_data)
   );

   tsu_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (q_stat)
   );

   tsu_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (q_head),
      .q_stat (q_stat),
      .q_pop  (q_pop),
      .rsp    (rsp_chan)
   );

endmodule
